// ----- hdl/paired_read_concordance_check_macros.svh -----
// Assertion macros used by the concordance check top level.
`ifndef PAIRED_READ_CONCORDANCE_CHECK_MACROS_SVH
`define PAIRED_READ_CONCORDANCE_CHECK_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRCC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/prcc_pkg.sv -----
// Shared types, widths and constants of the paired-read concordance check.
package prcc_pkg;

    localparam int POS_WIDTH    = 32;
    localparam int REF_ID_WIDTH = 16;

    localparam int POS_PORT_W = 32;
    localparam int REF_PORT_W = 16;
    localparam int SPAN_W     = 16;
    localparam int TLEN_W     = 34;
    localparam int COORD_W    = 34;
    localparam int INSERT_W   = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // Only the low POS_WIDTH / REF_ID_WIDTH bits of the port fields take part.
    localparam logic [POS_PORT_W-1:0] POS_MASK = {POS_PORT_W{1'b1}} >>
        ((POS_WIDTH >= POS_PORT_W) ? 0 : (POS_PORT_W - POS_WIDTH));
    localparam logic [REF_PORT_W-1:0] REF_MASK = {REF_PORT_W{1'b1}} >>
        ((REF_ID_WIDTH >= REF_PORT_W) ? 0 : (REF_PORT_W - REF_ID_WIDTH));

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [1:0] {
        ORIENT_FF = 2'd0,
        ORIENT_FR = 2'd1,
        ORIENT_RF = 2'd2
    } orient_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIENT         = 3'd0,
        CFG_MIN_INSERT     = 3'd1,
        CFG_MAX_INSERT     = 3'd2,
        CFG_ALLOW_CONTAIN  = 3'd3,
        CFG_ALLOW_OVERLAP  = 3'd4,
        CFG_ALLOW_DOVETAIL = 3'd5
    } cfg_reg_e;

    typedef struct packed {
        orient_e               orientation_mode;
        logic [INSERT_W-1:0]   min_insert;
        logic [INSERT_W-1:0]   max_insert;
        logic                  allow_contain;
        logic                  allow_overlap;
        logic                  allow_dovetail;
    } cfg_t;

    localparam orient_e             RST_ORIENT     = ORIENT_FR;
    localparam logic [INSERT_W-1:0] RST_MIN_INSERT = 32'd0;
    localparam logic [INSERT_W-1:0] RST_MAX_INSERT = 32'd500;

endpackage

// ----- hdl/prcc_ifs.sv -----
// Valid/ready channel interfaces for alignment pairs and concordance results.
interface prcc_pair_if;
    logic                              valid;
    logic                              ready;
    logic [prcc_pkg::REF_PORT_W-1:0]   ref_id_first;
    logic [prcc_pkg::POS_PORT_W-1:0]   pos_first;
    logic [prcc_pkg::SPAN_W-1:0]       span_first;
    logic                              rev_first;
    logic [prcc_pkg::REF_PORT_W-1:0]   ref_id_second;
    logic [prcc_pkg::POS_PORT_W-1:0]   pos_second;
    logic [prcc_pkg::SPAN_W-1:0]       span_second;
    logic                              rev_second;

    modport source (
        output valid, ref_id_first, pos_first, span_first, rev_first,
               ref_id_second, pos_second, span_second, rev_second,
        input  ready
    );
    modport sink (
        input  valid, ref_id_first, pos_first, span_first, rev_first,
               ref_id_second, pos_second, span_second, rev_second,
        output ready
    );
endinterface

interface prcc_result_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 is_concordant;
    logic signed [prcc_pkg::TLEN_W-1:0]   tlen_first;
    logic signed [prcc_pkg::TLEN_W-1:0]   tlen_second;

    modport source (
        output valid, is_concordant, tlen_first, tlen_second,
        input  ready
    );
    modport sink (
        input  valid, is_concordant, tlen_first, tlen_second,
        output ready
    );
endinterface

// ----- hdl/prcc_cfg.sv -----
// Configuration register file of the concordance check.
module prcc_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [prcc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [prcc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output prcc_pkg::cfg_t                    cfg
);

    prcc_pkg::cfg_t cfg_reg;
    prcc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (prcc_pkg::cfg_reg_e'(cfg_index))
                prcc_pkg::CFG_ORIENT:
                    cfg_next.orientation_mode = prcc_pkg::orient_e'(cfg_data[1:0]);
                prcc_pkg::CFG_MIN_INSERT:
                    cfg_next.min_insert = cfg_data[prcc_pkg::INSERT_W-1:0];
                prcc_pkg::CFG_MAX_INSERT:
                    cfg_next.max_insert = cfg_data[prcc_pkg::INSERT_W-1:0];
                prcc_pkg::CFG_ALLOW_CONTAIN:
                    cfg_next.allow_contain = cfg_data[0];
                prcc_pkg::CFG_ALLOW_OVERLAP:
                    cfg_next.allow_overlap = cfg_data[0];
                prcc_pkg::CFG_ALLOW_DOVETAIL:
                    cfg_next.allow_dovetail = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.orientation_mode <= prcc_pkg::RST_ORIENT;
            cfg_reg.min_insert       <= prcc_pkg::RST_MIN_INSERT;
            cfg_reg.max_insert       <= prcc_pkg::RST_MAX_INSERT;
            cfg_reg.allow_contain    <= 1'b0;
            cfg_reg.allow_overlap    <= 1'b1;
            cfg_reg.allow_dovetail   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/paired_read_concordance_check.sv -----
// Top level of the paired-read concordance and template length check.
// Four register stages: mate ends, comparisons, fragment span, verdict and output.
// A result is offered once its pair beat has passed stages 1, 2, 3 and the output register.
// Throughput is one pair per cycle; a stall holds an occupied stage only if all later stages are full.
// Reset empties the pipeline and loads the default pairing rules.
`include "paired_read_concordance_check_macros.svh"

module paired_read_concordance_check (
    input  logic                              clk,
    input  logic                              rst_n,
    prcc_pair_if.sink                         pair,
    prcc_result_if.source                     result,
    input  logic                              cfg_we,
    input  logic [prcc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [prcc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    prcc_pkg::cfg_t cfg;

    prcc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stage ready chain: a stage may load when it is empty or draining.
    logic rdy1, rdy2, rdy3, rdy4;
    logic s1_v_reg, s2_v_reg, s3_v_reg, out_v_reg;

    assign rdy4       = !out_v_reg || result.ready;
    assign rdy3       = !s3_v_reg || rdy4;
    assign rdy2       = !s2_v_reg || rdy3;
    assign rdy1       = !s1_v_reg || rdy2;
    assign pair.ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                s1_v_reg <= pair.valid;
            if (rdy2)
                s2_v_reg <= s1_v_reg;
            if (rdy3)
                s3_v_reg <= s2_v_reg;
            if (rdy4)
                out_v_reg <= s3_v_reg;
        end
    end

    // Stage 1: widen positions, form mate ends and compare reference ids.
    prcc_pkg::coord_t b1_next, b2_next, e1_next, e2_next;
    prcc_pkg::coord_t s1_b1_reg, s1_b2_reg, s1_e1_reg, s1_e2_reg;
    logic             req_next;
    logic             s1_req_reg, s1_rv1_reg, s1_rv2_reg;

    always_comb
    begin
        b1_next  = prcc_pkg::coord_t'({2'b00, pair.pos_first & prcc_pkg::POS_MASK});
        b2_next  = prcc_pkg::coord_t'({2'b00, pair.pos_second & prcc_pkg::POS_MASK});
        e1_next  = b1_next + prcc_pkg::coord_t'({18'd0, pair.span_first})
                   - prcc_pkg::coord_t'(1);
        e2_next  = b2_next + prcc_pkg::coord_t'({18'd0, pair.span_second})
                   - prcc_pkg::coord_t'(1);
        req_next = (pair.ref_id_first & prcc_pkg::REF_MASK)
                   == (pair.ref_id_second & prcc_pkg::REF_MASK);
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_b1_reg  <= b1_next;
            s1_b2_reg  <= b2_next;
            s1_e1_reg  <= e1_next;
            s1_e2_reg  <= e2_next;
            s1_req_reg <= req_next;
            s1_rv1_reg <= pair.rev_first;
            s1_rv2_reg <= pair.rev_second;
        end
    end

    // Stage 2: all position comparisons, orientation, fragment bounds.
    prcc_pkg::coord_t p1, p2;
    prcc_pkg::coord_t s2_lo_reg, s2_hi_reg;
    logic s2_b_lt12_reg, s2_b_lt21_reg, s2_e_lt12_reg, s2_e_lt21_reg;
    logic s2_b2_le_e1_reg, s2_e2_ge_b1_reg, s2_p_gt12_reg, s2_p_gt21_reg;
    logic s2_req_reg, s2_orient_ok_reg, s2_first_left_reg;
    logic orient_ok, first_left;

    always_comb
    begin
        p1 = s1_rv1_reg ? s1_e1_reg : s1_b1_reg;
        p2 = s1_rv2_reg ? s1_e2_reg : s1_b2_reg;
        case (cfg.orientation_mode)
            prcc_pkg::ORIENT_FF:
            begin
                orient_ok  = (s1_rv1_reg == s1_rv2_reg);
                first_left = !s1_rv1_reg;
            end
            prcc_pkg::ORIENT_FR:
            begin
                orient_ok  = (s1_rv1_reg != s1_rv2_reg);
                first_left = !s1_rv1_reg;
            end
            default:
            begin
                // Reverse-forward, and the unused code behaves the same way.
                orient_ok  = (s1_rv1_reg != s1_rv2_reg);
                first_left = s1_rv1_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            s2_b_lt12_reg     <= s1_b1_reg < s1_b2_reg;
            s2_b_lt21_reg     <= s1_b2_reg < s1_b1_reg;
            s2_e_lt12_reg     <= s1_e1_reg < s1_e2_reg;
            s2_e_lt21_reg     <= s1_e2_reg < s1_e1_reg;
            s2_b2_le_e1_reg   <= s1_b2_reg <= s1_e1_reg;
            s2_e2_ge_b1_reg   <= s1_e2_reg >= s1_b1_reg;
            s2_p_gt12_reg     <= p1 > p2;
            s2_p_gt21_reg     <= p2 > p1;
            s2_lo_reg         <= (s1_b1_reg < s1_b2_reg) ? s1_b1_reg : s1_b2_reg;
            s2_hi_reg         <= (s1_e1_reg > s1_e2_reg) ? s1_e1_reg : s1_e2_reg;
            s2_req_reg        <= s1_req_reg;
            s2_orient_ok_reg  <= orient_ok;
            s2_first_left_reg <= first_left;
        end
    end

    // Stage 3: fragment span and layout rules.
    logic contain, overlap, misordered, layout_ok;
    prcc_pkg::coord_t s3_size_reg;
    logic s3_layout_ok_reg, s3_req_reg, s3_neg1_reg, s3_neg2_reg;

    always_comb
    begin
        contain    = (!s2_b_lt12_reg && !s2_e_lt21_reg)
                     || (!s2_b_lt21_reg && !s2_e_lt12_reg);
        overlap    = contain
                     || (!s2_b_lt21_reg && s2_b2_le_e1_reg)
                     || (s2_e2_ge_b1_reg && !s2_e_lt12_reg);
        misordered = s2_first_left_reg ? s2_b_lt21_reg : s2_b_lt12_reg;
        layout_ok  = s2_orient_ok_reg
                     && !(contain && !cfg.allow_contain)
                     && !(overlap && !cfg.allow_overlap)
                     && !(misordered && (!overlap || !cfg.allow_dovetail));
    end

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            s3_size_reg      <= s2_hi_reg - s2_lo_reg + prcc_pkg::coord_t'(1);
            s3_layout_ok_reg <= layout_ok;
            s3_req_reg       <= s2_req_reg;
            s3_neg1_reg      <= s2_p_gt12_reg;
            s3_neg2_reg      <= s2_p_gt21_reg;
        end
    end

    // Stage 4: insert limits, signed template lengths, output register.
    // The span is never negative and fits in the signed TLEN_W-bit template length.
    logic in_range;
    logic out_conc_reg;
    logic signed [prcc_pkg::TLEN_W-1:0] tlen1_next, tlen2_next;
    logic signed [prcc_pkg::TLEN_W-1:0] out_tlen1_reg, out_tlen2_reg;

    always_comb
    begin
        in_range = (s3_size_reg >= prcc_pkg::coord_t'({2'b00, cfg.min_insert}))
                   && (s3_size_reg <= prcc_pkg::coord_t'({2'b00, cfg.max_insert}));
        if (!s3_req_reg)
        begin
            tlen1_next = '0;
            tlen2_next = '0;
        end
        else
        begin
            tlen1_next = s3_neg1_reg ? -s3_size_reg : s3_size_reg;
            tlen2_next = s3_neg2_reg ? -s3_size_reg : s3_size_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            out_conc_reg  <= s3_req_reg && s3_layout_ok_reg && in_range;
            out_tlen1_reg <= tlen1_next;
            out_tlen2_reg <= tlen2_next;
        end
    end

    assign result.valid         = out_v_reg;
    assign result.is_concordant = out_conc_reg;
    assign result.tlen_first    = out_tlen1_reg;
    assign result.tlen_second   = out_tlen2_reg;

    `PRCC_ASSERT_NEXT(a_accept_fills_stage1, pair.valid && pair.ready, s1_v_reg, "accepted pair beat did not enter stage 1")
    `PRCC_ASSERT_NOW(a_tlen_not_both_negative, result.valid, !(result.tlen_first[prcc_pkg::TLEN_W-1] && result.tlen_second[prcc_pkg::TLEN_W-1]), "both template lengths negative")
    `PRCC_ASSERT_NEXT(a_orient_write_lands, cfg_we && (cfg_index == prcc_pkg::CFG_ORIENT), cfg.orientation_mode == $past(cfg_data[1:0]), "orientation write not applied")

endmodule
